// File: hw/rtl/cpd_pkg.sv
// Package: register indexes and the CRC-8 byte update for the frame deframer.
package cpd_pkg;

	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		REG_START_BYTE = 2'd0,
		REG_MIN_LENGTH = 2'd1,
		REG_MAX_LENGTH = 2'd2,
		REG_CRC_POLY   = 2'd3
	} reg_index_t;

	localparam byte_t START_BYTE_RST = 8'h00;
	localparam byte_t MIN_LENGTH_RST = 8'h04;
	localparam byte_t MAX_LENGTH_RST = 8'hFF;
	localparam byte_t CRC_POLY_RST   = 8'h07;

	// MSB-first, non-reflected CRC-8 update over one byte
	function automatic byte_t crc8_byte(input byte_t crc, input byte_t data, input byte_t poly);
		byte_t v;
		v = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ poly;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

// File: hw/rtl/crc8_packet_deframer_unit.sv
// Frame deframer: start byte, length byte, payload and trailing CRC-8 check.
// Items pass the input register, then the result register; the parser state updates on that move.
// Throughput: one item per cycle while out_stall does not hold the result register.
// Reset: asynchronous, active low; registers return to start 0, min 4, max 255, poly 7,
// and the parser returns to index 0, CRC 0, expected length 255.
module crc8_packet_deframer_unit
	import cpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] frame_byte,
	output logic       accepted,
	output logic [7:0] byte_position,
	output logic       frame_end,
	output logic       frame_good
);

	byte_t start_byte_q, min_length_q, max_length_q, crc_poly_q;
	byte_t byte_index_q, expected_length_q, running_crc_q;

	logic  valid_s1;
	byte_t rx_byte_s1;
	logic  valid_s2;
	byte_t frame_byte_s2;
	logic  accepted_s2;
	byte_t byte_position_s2;
	logic  frame_end_s2;
	logic  frame_good_s2;

	logic  advance;
	logic  take_in;
	byte_t exp_len;
	byte_t next_index;
	byte_t next_crc;
	logic  bad;
	logic  done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			min_length_q <= MIN_LENGTH_RST;
			max_length_q <= MAX_LENGTH_RST;
			crc_poly_q   <= CRC_POLY_RST;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_START_BYTE: start_byte_q <= cfg_data;
				REG_MIN_LENGTH: min_length_q <= cfg_data;
				REG_MAX_LENGTH: max_length_q <= cfg_data;
				REG_CRC_POLY:   crc_poly_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	always_comb begin
		exp_len    = (byte_index_q == 8'd1) ? rx_byte_s1 : expected_length_q;
		bad        = (byte_index_q == 8'd0 && rx_byte_s1 != start_byte_q)
			|| (exp_len < min_length_q)
			|| (byte_index_q == 8'd1 && exp_len > max_length_q);
		next_index = byte_index_q + 8'd1;
		next_crc   = crc8_byte(running_crc_q, rx_byte_s1, crc_poly_q);
		done       = !bad && (next_index == exp_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q      <= 8'd0;
			expected_length_q <= MAX_LENGTH_RST;
			running_crc_q     <= 8'd0;
		end else if (advance) begin
			if (bad || done) begin
				byte_index_q      <= 8'd0;
				expected_length_q <= max_length_q;
				running_crc_q     <= 8'd0;
			end else begin
				byte_index_q      <= next_index;
				expected_length_q <= exp_len;
				running_crc_q     <= next_crc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_byte_s2    <= rx_byte_s1;
			accepted_s2      <= !bad;
			byte_position_s2 <= bad ? 8'd0 : byte_index_q;
			frame_end_s2     <= done;
			frame_good_s2    <= done && (next_crc == 8'd0);
		end
	end

	assign out_valid     = valid_s2;
	assign frame_byte    = frame_byte_s2;
	assign accepted      = accepted_s2;
	assign byte_position = byte_position_s2;
	assign frame_end     = frame_end_s2;
	assign frame_good    = frame_good_s2;

endmodule

// File: hw/rtl/cpd_checker.sv
// Checker on the deframer ports, bound to the deframer module.
module cpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] rx_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] frame_byte,
	input logic       accepted,
	input logic [7:0] byte_position,
	input logic       frame_end,
	input logic       frame_good
);

	a_end_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> accepted)
		else $error("frame end on a rejected item");

	a_good_needs_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_good |-> frame_end)
		else $error("frame good without frame end");

	a_reject_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> byte_position == 8'd0)
		else $error("rejected item carries a position");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_byte) && $stable(byte_position))
		else $error("stalled result changed");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(rx_byte))
		else $error("stalled input item changed");

endmodule

bind crc8_packet_deframer_unit cpd_checker u_cpd_checker (.*);
